// ===== rtl/core/phgl_pkg.sv =====
// Shared types, constants and the phred-to-linear table for the haplotype likelihood core.
package phgl_pkg;

    localparam int unsigned PHRED_LEVELS_DEF  = 256;
    localparam int unsigned OUT_FRAC_BITS_DEF = 16;

    // linear values are Q1.24, at most 1.0
    localparam int unsigned LIN_W = 25;
    // widest term: 2*(a+b+c) <= 6.0 in Q24
    localparam int unsigned SUM_W = 27;
    // at and above this phred difference the linear value rounds to zero
    localparam int unsigned LIN_ZERO_AT = 80;

    localparam int unsigned OUT_W      = 17;
    localparam int unsigned S_TDATA_W  = 32;
    localparam int unsigned M_TDATA_W  = 40;
    localparam logic [1:0]  PLOIDY_RST = 2'd2;
    localparam logic [1:0]  PLOIDY_HAPLOID = 2'd1;

    // round(10^(-d/10) * 2^24) by steps of 10^(d div 10), d = 0..79
    localparam logic [LIN_W-1:0] LIN_Q24 [LIN_ZERO_AT] = '{
        25'd16777216, 25'd13326616, 25'd10585708, 25'd8408526, 25'd6679130,
        25'd5305422,  25'd4214246,  25'd3347495,  25'd2659010, 25'd2112126,
        25'd1677722,  25'd1332662,  25'd1058571,  25'd840853,  25'd667913,
        25'd530542,   25'd421425,   25'd334750,   25'd265901,  25'd211213,
        25'd167772,   25'd133266,   25'd105857,   25'd84085,   25'd66791,
        25'd53054,    25'd42142,    25'd33475,    25'd26590,   25'd21121,
        25'd16777,    25'd13327,    25'd10586,    25'd8409,    25'd6679,
        25'd5305,     25'd4214,     25'd3347,     25'd2659,    25'd2112,
        25'd1678,     25'd1333,     25'd1059,     25'd841,     25'd668,
        25'd531,      25'd421,      25'd335,      25'd266,     25'd211,
        25'd168,      25'd133,      25'd106,      25'd84,      25'd67,
        25'd53,       25'd42,       25'd33,       25'd27,      25'd21,
        25'd17,       25'd13,       25'd11,       25'd8,       25'd7,
        25'd5,        25'd4,        25'd3,        25'd3,       25'd2,
        25'd2,        25'd1,        25'd1,        25'd1,       25'd1,
        25'd1,        25'd0,        25'd0,        25'd0,       25'd0
    };

    // which genotype terms form the two ratios
    typedef enum logic [1:0] {
        SEL_HAPLOID,
        SEL_DIPLOID,
        SEL_COND_REF,
        SEL_COND_ALT
    } sel_t;

    typedef struct packed {
        logic             den_zero;
        logic             last;
    } div_side_t;

    typedef struct packed {
        logic [SUM_W-1:0] nr;
        logic [SUM_W-1:0] na;
        logic [SUM_W-1:0] den;
        div_side_t        side;
    } div_req_t;

    function automatic logic [LIN_W-1:0] lin_q24(input logic [7:0] d);
        logic [LIN_W-1:0] v;
        if (d >= 8'(LIN_ZERO_AT))
        begin
            v = '0;
        end
        else
        begin
            v = LIN_Q24[d[6:0]];
        end
        return v;
    endfunction

endpackage

// ===== rtl/core/phred_genotype_to_haplotype_likelihood_core.sv =====
// Phred genotype likelihoods to haplotype allele likelihoods, stream top level.
// The divider retires one quotient bit per pipeline stage.
// Throughput: one beat per cycle; every stage stalls on its own, bubbles close up.
// Reset (rst_n low, async): all pipeline valid bits clear, sample_ploidy = 2.
module phred_genotype_to_haplotype_likelihood_core #(
    parameter int unsigned PHRED_LEVELS  = phgl_pkg::PHRED_LEVELS_DEF,
    parameter int unsigned OUT_FRAC_BITS = phgl_pkg::OUT_FRAC_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // phred_hom_ref[7:0], phred_het[15:8], phred_hom_alt[23:16], other_allele[24]
    input  logic [phgl_pkg::S_TDATA_W-1:0]   s_tdata,
    // mode[0]
    input  logic [0:0]                       s_tuser,
    input  logic                             s_tlast,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // ref_likelihood[16:0], alt_likelihood[33:17]
    output logic [phgl_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic                             m_tlast,
    input  logic                             cfg_we,
    input  logic [1:0]                       cfg_wdata
);

    localparam int unsigned QW = OUT_FRAC_BITS + 1;
    localparam int unsigned OW = phgl_pkg::OUT_W;
    localparam logic [QW-1:0] HALF_Q = QW'(1) << (OUT_FRAC_BITS - 1);

    logic [1:0] ploidy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ploidy_reg <= phgl_pkg::PLOIDY_RST;
        end
        else if (cfg_we)
        begin
            ploidy_reg <= cfg_wdata;
        end
    end

    logic               fr_valid, fr_ready;
    phgl_pkg::div_req_t fr_req;

    phgl_front #(
        .PHRED_LEVELS (PHRED_LEVELS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .mode          (s_tuser[0]),
        .phred_hom_ref (s_tdata[7:0]),
        .phred_het     (s_tdata[15:8]),
        .phred_hom_alt (s_tdata[23:16]),
        .other_allele  (s_tdata[24]),
        .last_in       (s_tlast),
        .sample_ploidy (ploidy_reg),
        .out_valid     (fr_valid),
        .out_ready     (fr_ready),
        .out_req       (fr_req)
    );

    logic                dv_valid, dv_ready;
    logic [QW-1:0]       dv_q_ref, dv_q_alt;
    phgl_pkg::div_side_t dv_side;

    phgl_div #(
        .OUT_FRAC_BITS (OUT_FRAC_BITS)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fr_valid),
        .in_ready  (fr_ready),
        .in_req    (fr_req),
        .out_valid (dv_valid),
        .out_ready (dv_ready),
        .out_q_ref (dv_q_ref),
        .out_q_alt (dv_q_alt),
        .out_side  (dv_side)
    );

    // ---- output register
    logic          out_vld_reg;
    logic [OW-1:0] ref_reg, alt_reg;
    logic          last_reg;
    logic [QW-1:0] ref_next, alt_next;

    assign dv_ready = ~out_vld_reg | m_tready;

    // empty pair: both terms underflowed, report one half each
    assign ref_next = dv_side.den_zero ? HALF_Q : dv_q_ref;
    assign alt_next = dv_side.den_zero ? HALF_Q : dv_q_alt;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (dv_ready)
        begin
            out_vld_reg <= dv_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (dv_ready)
        begin
            ref_reg  <= OW'(ref_next);
            alt_reg  <= OW'(alt_next);
            last_reg <= dv_side.last;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {(phgl_pkg::M_TDATA_W - 2 * OW)'(0), alt_reg, ref_reg};
    assign m_tlast  = last_reg;

endmodule

// ===== rtl/core/phgl_front.sv =====
// Front pipeline: clamp and minimum, linear lookup, numerator and denominator forming.
module phgl_front #(
    parameter int unsigned PHRED_LEVELS = phgl_pkg::PHRED_LEVELS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               mode,
    input  logic [7:0]         phred_hom_ref,
    input  logic [7:0]         phred_het,
    input  logic [7:0]         phred_hom_alt,
    input  logic               other_allele,
    input  logic               last_in,
    input  logic [1:0]         sample_ploidy,
    output logic               out_valid,
    input  logic               out_ready,
    output phgl_pkg::div_req_t out_req
);

    localparam logic [7:0] PHRED_MAX = 8'(PHRED_LEVELS - 1);
    localparam int unsigned SW = phgl_pkg::SUM_W;

    logic [2:0] vld_reg;
    logic [2:0] en;

    assign en[2] = ~vld_reg[2] | out_ready;
    assign en[1] = ~vld_reg[1] | en[2];
    assign en[0] = ~vld_reg[0] | en[1];

    assign in_ready  = en[0];
    assign out_valid = vld_reg[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                vld_reg[0] <= in_valid;
            end
            if (en[1])
            begin
                vld_reg[1] <= vld_reg[0];
            end
            if (en[2])
            begin
                vld_reg[2] <= vld_reg[1];
            end
        end
    end

    // ---- stage 1: clamp, minimum, differences
    logic [7:0]     q0, q1, q2, min01, m;
    logic [7:0]     d0_next, d1_next, d2_next;
    phgl_pkg::sel_t sel1_next;

    always_comb
    begin
        q0 = (phred_hom_ref > PHRED_MAX) ? PHRED_MAX : phred_hom_ref;
        q1 = (phred_het     > PHRED_MAX) ? PHRED_MAX : phred_het;
        q2 = (phred_hom_alt > PHRED_MAX) ? PHRED_MAX : phred_hom_alt;
        if (!mode && sample_ploidy == phgl_pkg::PLOIDY_HAPLOID)
        begin
            sel1_next = phgl_pkg::SEL_HAPLOID;
        end
        else if (!mode)
        begin
            sel1_next = phgl_pkg::SEL_DIPLOID;
        end
        else if (!other_allele)
        begin
            sel1_next = phgl_pkg::SEL_COND_REF;
        end
        else
        begin
            sel1_next = phgl_pkg::SEL_COND_ALT;
        end
        min01 = (q0 < q1) ? q0 : q1;
        // hom alt takes no part in the minimum when haploid
        m = (sel1_next == phgl_pkg::SEL_HAPLOID || q2 >= min01) ? min01 : q2;
        d0_next = q0 - m;
        d1_next = q1 - m;
        d2_next = q2 - m;
    end

    logic [7:0]     d0_reg, d1_reg, d2_reg;
    phgl_pkg::sel_t sel1_reg;
    logic           last1_reg;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            d0_reg    <= d0_next;
            d1_reg    <= d1_next;
            d2_reg    <= d2_next;
            sel1_reg  <= sel1_next;
            last1_reg <= last_in;
        end
    end

    // ---- stage 2: table lookup
    logic [phgl_pkg::LIN_W-1:0] a_reg, b_reg, c_reg;
    phgl_pkg::sel_t             sel2_reg;
    logic                       last2_reg;

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            a_reg     <= phgl_pkg::lin_q24(d0_reg);
            b_reg     <= phgl_pkg::lin_q24(d1_reg);
            c_reg     <= phgl_pkg::lin_q24(d2_reg);
            sel2_reg  <= sel1_reg;
            last2_reg <= last1_reg;
        end
    end

    // ---- stage 3: ratio terms
    logic [SW-1:0]      a_x, b_x, c_x;
    phgl_pkg::div_req_t req_next;
    phgl_pkg::div_req_t req_reg;

    always_comb
    begin
        a_x = SW'(a_reg);
        b_x = SW'(b_reg);
        c_x = SW'(c_reg);
        req_next.side.last = last2_reg;
        unique case (sel2_reg)
            phgl_pkg::SEL_HAPLOID,
            phgl_pkg::SEL_COND_REF:
            begin
                req_next.nr  = a_x;
                req_next.na  = b_x;
                req_next.den = a_x + b_x;
            end
            phgl_pkg::SEL_DIPLOID:
            begin
                // het term split half to each allele
                req_next.nr  = (a_x << 1) + b_x;
                req_next.na  = b_x + (c_x << 1);
                req_next.den = (a_x + b_x + c_x) << 1;
            end
            phgl_pkg::SEL_COND_ALT:
            begin
                req_next.nr  = b_x;
                req_next.na  = c_x;
                req_next.den = b_x + c_x;
            end
            default:
            begin
                req_next.nr  = a_x;
                req_next.na  = b_x;
                req_next.den = a_x + b_x;
            end
        endcase
        req_next.side.den_zero = (req_next.den == '0);
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            req_reg <= req_next;
        end
    end

    assign out_req = req_reg;

endmodule

// ===== rtl/core/phgl_div.sv =====
// Pipelined restoring divider pair: one quotient bit per stage, rounded half up.
module phgl_div #(
    parameter int unsigned OUT_FRAC_BITS = phgl_pkg::OUT_FRAC_BITS_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  phgl_pkg::div_req_t      in_req,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [OUT_FRAC_BITS:0]  out_q_ref,
    output logic [OUT_FRAC_BITS:0]  out_q_alt,
    output phgl_pkg::div_side_t     out_side
);

    localparam int unsigned QW = OUT_FRAC_BITS + 1;
    // prep stage plus one stage per quotient bit
    localparam int unsigned NS = OUT_FRAC_BITS + 2;
    localparam int unsigned SW = phgl_pkg::SUM_W;
    localparam int unsigned NW = SW + OUT_FRAC_BITS + 1;
    localparam int unsigned RW = SW + 1;

    logic [NS-1:0]       vld_reg;
    logic [NS-1:0]       en;
    logic [QW-1:0]       n_ref_reg   [NS];
    logic [QW-1:0]       n_alt_reg   [NS];
    logic [RW-1:0]       rem_ref_reg [NS];
    logic [RW-1:0]       rem_alt_reg [NS];
    logic [QW-1:0]       q_ref_reg   [NS];
    logic [QW-1:0]       q_alt_reg   [NS];
    logic [SW-1:0]       den_reg     [NS];
    phgl_pkg::div_side_t side_reg    [NS];

    assign en[NS-1] = ~vld_reg[NS-1] | out_ready;

    for (genvar i = 0; i < NS - 1; i++)
    begin : g_en
        assign en[i] = ~vld_reg[i] | en[i+1];
    end

    assign in_ready  = en[0];
    assign out_valid = vld_reg[NS-1];
    assign out_q_ref = q_ref_reg[NS-1];
    assign out_q_alt = q_alt_reg[NS-1];
    assign out_side  = side_reg[NS-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < NS; i++)
            begin
                if (en[i])
                begin
                    vld_reg[i] <= (i == 0) ? in_valid : vld_reg[(i == 0) ? 0 : i - 1];
                end
            end
        end
    end

    // ---- prep: dividend = num * 2^F + den / 2
    logic [NW-1:0] n_ref_next, n_alt_next;

    assign n_ref_next = (NW'(in_req.nr) << OUT_FRAC_BITS) + NW'(in_req.den >> 1);
    assign n_alt_next = (NW'(in_req.na) << OUT_FRAC_BITS) + NW'(in_req.den >> 1);

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            n_ref_reg[0]   <= n_ref_next[QW-1:0];
            n_alt_reg[0]   <= n_alt_next[QW-1:0];
            // upper part is below den since num <= den
            rem_ref_reg[0] <= RW'(n_ref_next[NW-1:QW]);
            rem_alt_reg[0] <= RW'(n_alt_next[NW-1:QW]);
            q_ref_reg[0]   <= '0;
            q_alt_reg[0]   <= '0;
            den_reg[0]     <= in_req.den;
            side_reg[0]    <= in_req.side;
        end
    end

    // ---- bit stages, MSB of the quotient first
    for (genvar i = 1; i < NS; i++)
    begin : g_step
        logic [RW-1:0] sh_ref, sh_alt;
        logic [RW:0]   df_ref, df_alt;
        logic          ge_ref, ge_alt;

        always_comb
        begin
            sh_ref = {rem_ref_reg[i-1][RW-2:0], n_ref_reg[i-1][NS-1-i]};
            sh_alt = {rem_alt_reg[i-1][RW-2:0], n_alt_reg[i-1][NS-1-i]};
            df_ref = {1'b0, sh_ref} - {2'b00, den_reg[i-1]};
            df_alt = {1'b0, sh_alt} - {2'b00, den_reg[i-1]};
            ge_ref = ~df_ref[RW];
            ge_alt = ~df_alt[RW];
        end

        always_ff @(posedge clk)
        begin
            if (en[i])
            begin
                n_ref_reg[i]   <= n_ref_reg[i-1];
                n_alt_reg[i]   <= n_alt_reg[i-1];
                rem_ref_reg[i] <= ge_ref ? df_ref[RW-1:0] : sh_ref;
                rem_alt_reg[i] <= ge_alt ? df_alt[RW-1:0] : sh_alt;
                q_ref_reg[i]   <= {q_ref_reg[i-1][QW-2:0], ge_ref};
                q_alt_reg[i]   <= {q_alt_reg[i-1][QW-2:0], ge_alt};
                den_reg[i]     <= den_reg[i-1];
                side_reg[i]    <= side_reg[i-1];
            end
        end
    end

endmodule
